// ----- rtl/nd_pkg.sv -----
// Shared constants, types and a helper function for the NFA to DFA subset builder.
package nd_pkg;

	localparam int NFA_N  = 16;
	localparam int SYM_N  = 4;
	localparam int DFA_N  = 64;
	localparam int SET_W  = 16;
	localparam int ST_W   = 4;
	localparam int SYM_W  = 2;
	localparam int TA_W   = ST_W + SYM_W;
	localparam int DIDX_W = 6;
	localparam int CNT_W  = 7;
	localparam int NXT_W  = 7;
	localparam int NS_W   = 5;
	localparam int NSYM_W = 3;
	localparam int ACT_W  = 2;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	localparam logic [NXT_W-1:0] NO_SUCC = NXT_W'(DFA_N);

	localparam logic [ACT_W-1:0] ACT_SYM   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_EPS   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BUILD = 2'd2;

	localparam logic [CFG_AW-1:0] REG_NUM_STATES  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_NUM_SYMBOLS = 2'd1;
	localparam logic [CFG_AW-1:0] REG_START_STATE = 2'd2;
	localparam logic [CFG_AW-1:0] REG_ACCEPT_MASK = 2'd3;

	typedef struct packed {
		logic              sym_we;
		logic              eps_we;
		logic [ST_W-1:0]   state;
		logic [SYM_W-1:0]  sym;
		logic [SET_W-1:0]  data;
	} tm_wr_t;

	function automatic logic [ST_W-1:0] low_bit(input logic [SET_W-1:0] v);
		logic [ST_W-1:0] r;
		r = '0;
		for (int i = SET_W - 1; i >= 0; i--) begin
			if (v[i]) r = ST_W'(i);
		end
		return r;
	endfunction

endpackage

// ----- rtl/nd_tmem.sv -----
// Transition memories: per-symbol target sets and epsilon target sets.
module nd_tmem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nd_pkg::tm_wr_t            wr,
	input  logic [nd_pkg::TA_W-1:0]   sym_raddr,
	input  logic [nd_pkg::ST_W-1:0]   eps_raddr,
	output logic [nd_pkg::SET_W-1:0]  sym_rdata,
	output logic [nd_pkg::SET_W-1:0]  eps_rdata
);
	import nd_pkg::*;

	logic [SET_W-1:0] sym_mem [SYM_N*NFA_N];
	logic [SET_W-1:0] eps_mem [NFA_N];
	logic [SYM_N*NFA_N-1:0] sym_vld_q;
	logic [NFA_N-1:0] eps_vld_q;
	logic [TA_W-1:0] waddr;

	assign waddr = {wr.state, wr.sym};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_vld_q <= '0;
			eps_vld_q <= '0;
		end else begin
			if (wr.sym_we) sym_vld_q[waddr] <= 1'b1;
			if (wr.eps_we) eps_vld_q[wr.state] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.sym_we) sym_mem[waddr] <= wr.data;
		if (wr.eps_we) eps_mem[wr.state] <= wr.data;
		sym_rdata <= sym_vld_q[sym_raddr] ? sym_mem[sym_raddr] : '0;
		eps_rdata <= eps_vld_q[eps_raddr] ? eps_mem[eps_raddr] : '0;
	end

endmodule

// ----- rtl/nd_dtab.sv -----
// DFA state table: one NFA set per discovered DFA state.
module nd_dtab (
	input  logic                       clk,
	input  logic                       we,
	input  logic [nd_pkg::DIDX_W-1:0]  waddr,
	input  logic [nd_pkg::SET_W-1:0]   wdata,
	input  logic [nd_pkg::DIDX_W-1:0]  raddr,
	output logic [nd_pkg::SET_W-1:0]   rdata
);
	import nd_pkg::*;

	logic [SET_W-1:0] mem [DFA_N];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/nfa_to_dfa_subset_builder.sv -----
// Top level of the NFA to DFA subset builder: build sequencer and result register.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   action, state_index, symbol_index, target_set
//  out      output     out_valid / out_ready dfa_index, nfa_set, next_on_0..3, flags
//  cfg      input      cfg_we                cfg_addr, cfg_wdata
//
// A build is run by a sequencer over three memories with registered reads: each closure
// step, each symbol gather step and each table compare is a read state followed by a
// wait state. Input is taken only while the sequencer is idle; a stalled result word
// holds the sequencer. Reset clears all control state and the transition valid bits,
// but not the DFA state table.
module nfa_to_dfa_subset_builder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nd_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [nd_pkg::CFG_DW-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [nd_pkg::ACT_W-1:0]      action,
	input  logic [nd_pkg::ST_W-1:0]       state_index,
	input  logic [nd_pkg::SYM_W-1:0]      symbol_index,
	input  logic [nd_pkg::SET_W-1:0]      target_set,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nd_pkg::DIDX_W-1:0]     dfa_index,
	output logic [nd_pkg::SET_W-1:0]      nfa_set,
	output logic [nd_pkg::NXT_W-1:0]      next_on_0,
	output logic [nd_pkg::NXT_W-1:0]      next_on_1,
	output logic [nd_pkg::NXT_W-1:0]      next_on_2,
	output logic [nd_pkg::NXT_W-1:0]      next_on_3,
	output logic                          accepting,
	output logic                          overflow,
	output logic                          last
);
	import nd_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_CL_RD  = 12'b000000000010,
		ST_CL_WT  = 12'b000000000100,
		ST_ROW_RD = 12'b000000001000,
		ST_ROW_WT = 12'b000000010000,
		ST_SYM    = 12'b000000100000,
		ST_SY_RD  = 12'b000001000000,
		ST_SY_WT  = 12'b000010000000,
		ST_SR_RD  = 12'b000100000000,
		ST_SR_WT  = 12'b001000000000,
		ST_EMIT   = 12'b010000000000,
		ST_CL_END = 12'b100000000000
	} fsm_t;

	fsm_t state_q;

	logic [NS_W-1:0]   num_states_q;
	logic [NSYM_W-1:0] num_symbols_q;
	logic [ST_W-1:0]   start_state_q;
	logic [SET_W-1:0]  accept_mask_q;

	logic [NS_W-1:0]   ns_eff;
	logic [NSYM_W-1:0] nsym_eff;
	logic [SET_W-1:0]  use_mask;

	logic [SET_W-1:0]  use_q;
	logic [NSYM_W-1:0] nsym_q;
	logic              cl_start_q;
	logic [SET_W-1:0]  set_q;
	logic [SET_W-1:0]  pend_q;
	logic [SET_W-1:0]  acc_q;
	logic [SET_W-1:0]  cur_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  head_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  j_q;
	logic [NSYM_W-1:0] s_q;
	logic              ovf_q;
	logic [NXT_W-1:0]  nxt_q [SYM_N];

	tm_wr_t            tw;
	logic [SET_W-1:0]  sym_rdata;
	logic [SET_W-1:0]  eps_rdata;
	logic [ST_W-1:0]   pick;
	logic              dt_we;
	logic [DIDX_W-1:0] dt_waddr;
	logic [SET_W-1:0]  dt_wdata;
	logic [DIDX_W-1:0] dt_raddr;
	logic [SET_W-1:0]  dt_rdata;
	logic [SET_W-1:0]  new_bits;
	logic              in_acc;

	always_comb begin
		if (num_states_q == '0) ns_eff = NS_W'(1);
		else if (num_states_q > NS_W'(NFA_N)) ns_eff = NS_W'(NFA_N);
		else ns_eff = num_states_q;
		if (num_symbols_q == '0) nsym_eff = NSYM_W'(1);
		else if (num_symbols_q > NSYM_W'(SYM_N)) nsym_eff = NSYM_W'(SYM_N);
		else nsym_eff = num_symbols_q;
		use_mask = SET_W'((32'd1 << ns_eff) - 32'd1);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		tw.sym_we = in_acc && (action == ACT_SYM);
		tw.eps_we = in_acc && (action == ACT_EPS);
		tw.state  = state_index;
		tw.sym    = symbol_index;
		tw.data   = target_set;
	end

	assign pick     = low_bit(pend_q);
	assign new_bits = eps_rdata & use_q & ~set_q;

	always_comb begin
		dt_we    = 1'b0;
		dt_waddr = count_q[DIDX_W-1:0];
		dt_wdata = set_q;
		if (state_q == ST_CL_END && cl_start_q) begin
			dt_we = 1'b1;
		end
		if (state_q == ST_SR_RD && j_q == count_q && count_q < CNT_W'(DFA_N)) begin
			dt_we = 1'b1;
		end
		dt_raddr = (state_q == ST_ROW_RD) ? head_q[DIDX_W-1:0] : j_q[DIDX_W-1:0];
	end

	nd_tmem u_tmem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (tw),
		.sym_raddr ({pick, s_q[SYM_W-1:0]}),
		.eps_raddr (pick),
		.sym_rdata (sym_rdata),
		.eps_rdata (eps_rdata)
	);

	nd_dtab u_dtab (
		.clk   (clk),
		.we    (dt_we),
		.waddr (dt_waddr),
		.wdata (dt_wdata),
		.raddr (dt_raddr),
		.rdata (dt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= NS_W'(NFA_N);
			num_symbols_q <= NSYM_W'(2);
			start_state_q <= '0;
			accept_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_NUM_STATES:  num_states_q  <= cfg_wdata[NS_W-1:0];
				REG_NUM_SYMBOLS: num_symbols_q <= cfg_wdata[NSYM_W-1:0];
				REG_START_STATE: start_state_q <= cfg_wdata[ST_W-1:0];
				REG_ACCEPT_MASK: accept_mask_q <= cfg_wdata[SET_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			use_q      <= '0;
			nsym_q     <= '0;
			cl_start_q <= 1'b0;
			set_q      <= '0;
			pend_q     <= '0;
			acc_q      <= '0;
			cur_q      <= '0;
			count_q    <= '0;
			head_q     <= '0;
			idx_q      <= '0;
			j_q        <= '0;
			s_q        <= '0;
			ovf_q      <= 1'b0;
			for (int k = 0; k < SYM_N; k++) nxt_q[k] <= NO_SUCC;
			out_valid  <= 1'b0;
			dfa_index  <= '0;
			nfa_set    <= '0;
			next_on_0  <= NO_SUCC;
			next_on_1  <= NO_SUCC;
			next_on_2  <= NO_SUCC;
			next_on_3  <= NO_SUCC;
			accepting  <= 1'b0;
			overflow   <= 1'b0;
			last       <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_EMIT) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && action == ACT_BUILD) begin
						use_q      <= use_mask;
						nsym_q     <= nsym_eff;
						cl_start_q <= 1'b1;
						set_q      <= SET_W'(32'd1 << start_state_q) & use_mask;
						pend_q     <= SET_W'(32'd1 << start_state_q) & use_mask;
						count_q    <= '0;
						head_q     <= '0;
						state_q    <= ST_CL_RD;
					end
				end
				ST_CL_RD: begin
					if (pend_q == '0) begin
						state_q <= ST_CL_END;
					end else begin
						pend_q  <= pend_q & (pend_q - SET_W'(1));
						state_q <= ST_CL_WT;
					end
				end
				ST_CL_WT: begin
					set_q   <= set_q | new_bits;
					pend_q  <= pend_q | new_bits;
					state_q <= ST_CL_RD;
				end
				ST_CL_END: begin
					if (cl_start_q) begin
						count_q <= CNT_W'(1);
						state_q <= ST_ROW_RD;
					end else if (set_q == '0) begin
						s_q     <= s_q + NSYM_W'(1);
						state_q <= ST_SYM;
					end else begin
						j_q     <= '0;
						state_q <= ST_SR_RD;
					end
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW_WT;
				end
				ST_ROW_WT: begin
					cur_q      <= dt_rdata;
					idx_q      <= head_q;
					head_q     <= head_q + CNT_W'(1);
					s_q        <= '0;
					ovf_q      <= 1'b0;
					cl_start_q <= 1'b0;
					for (int k = 0; k < SYM_N; k++) nxt_q[k] <= NO_SUCC;
					state_q    <= ST_SYM;
				end
				ST_SYM: begin
					if (s_q >= nsym_q) begin
						state_q <= ST_EMIT;
					end else begin
						acc_q   <= '0;
						pend_q  <= cur_q & use_q;
						state_q <= ST_SY_RD;
					end
				end
				ST_SY_RD: begin
					if (pend_q == '0) begin
						set_q   <= acc_q & use_q;
						pend_q  <= acc_q & use_q;
						state_q <= ST_CL_RD;
					end else begin
						pend_q  <= pend_q & (pend_q - SET_W'(1));
						state_q <= ST_SY_WT;
					end
				end
				ST_SY_WT: begin
					acc_q   <= acc_q | sym_rdata;
					state_q <= ST_SY_RD;
				end
				ST_SR_RD: begin
					if (j_q == count_q) begin
						if (count_q < CNT_W'(DFA_N)) begin
							nxt_q[s_q[SYM_W-1:0]] <= NXT_W'(count_q);
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						s_q     <= s_q + NSYM_W'(1);
						state_q <= ST_SYM;
					end else begin
						state_q <= ST_SR_WT;
					end
				end
				ST_SR_WT: begin
					if (dt_rdata == set_q) begin
						nxt_q[s_q[SYM_W-1:0]] <= NXT_W'(j_q);
						s_q     <= s_q + NSYM_W'(1);
						state_q <= ST_SYM;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= ST_SR_RD;
					end
				end
				ST_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						dfa_index <= idx_q[DIDX_W-1:0];
						nfa_set   <= cur_q;
						next_on_0 <= nxt_q[0];
						next_on_1 <= nxt_q[1];
						next_on_2 <= nxt_q[2];
						next_on_3 <= nxt_q[3];
						accepting <= |(cur_q & accept_mask_q);
						overflow  <= ovf_q;
						last      <= (head_q == count_q);
						state_q   <= (head_q == count_q) ? ST_IDLE : ST_ROW_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
